@@ hdl/csa_pkg.sv @@
`default_nettype none
package csa_pkg;

  // Command codes
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_EVICT  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_SIZE  = 3'd1;
  localparam logic [2:0] STAT_NO_SLOTS  = 3'd2;
  localparam logic [2:0] STAT_TBL_FULL  = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  localparam logic [3:0] CHUNK_LIMIT_RST = 4'd8;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  slots_wanted;
    logic [31:0] target_id;
  } csa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] given_id;
    logic [8:0]  first_slot;
    logic [6:0]  slot_count;
    logic        is_loaded;
  } csa_out_t;

endpackage
`default_nettype wire

@@ hdl/csa_freemap.sv @@
`default_nettype none
module csa_freemap #(
  parameter int ROWS  = 8,
  parameter int WIDTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   re_i,
  input  wire logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o,
  input  wire logic                                   we_i,
  input  wire logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i
);
  logic [WIDTH-1:0] mem_q [ROWS];
  logic [ROWS-1:0]  row_vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  // Row storage, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  // Track rows ever written; an unwritten row reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        row_vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= row_vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : {WIDTH{1'b1}};

endmodule
`default_nettype wire

@@ hdl/csa_table.sv @@
`default_nettype none
module csa_table #(
  parameter int DEPTH = 64,
  parameter int DW    = 48
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [DW-1:0]                            rdata_o,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [DW-1:0]                            wdata_i,
  input  wire logic                                     clr_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] caddr_i,
  output logic      [DEPTH-1:0]                         valid_o
);
  logic [DW-1:0]    mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;

  // Entry storage with registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

  // Live bits: set on write, drop on evict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (clr_i) begin
        valid_q[caddr_i] <= 1'b0;
      end
    end
  end

  assign valid_o = valid_q;

endmodule
`default_nettype wire

@@ hdl/contiguous_slot_allocator.sv @@
`default_nettype none
// Contiguous slot allocator.
// Command channel: in_i is taken at a clock edge with start_i high and busy_o
// low. Commands are create (find the first free run of slots_wanted slots
// inside one chunk, opening a new chunk when none fits), evict (free a block
// by id) and query (is the id live).
// Result channel: res_valid_o is high for exactly one cycle with res_o; the
// receiver cannot stall, so each result must be taken on that cycle.
// Config: cfg_we_i writes chunk_limit from cfg_wdata_i; write only while idle.
// Sequence: a bad-size create is answered from idle with no table sweep. Every
// other command first sweeps the block table one entry a cycle, stopping early
// on a hit. A create then reads each open chunk row (S_CHK, S_RDCAP) and tests
// one window start per cycle, up to CHUNK_SLOTS - slots_wanted + 1 per chunk.
// Evict then does a read-modify-write of the chunk row. The table sweep and the
// one-window-per-cycle chunk scan set the rate; one command is in flight.
// Reset: every slot free, no chunk open, id counter zero, table empty,
// chunk_limit 8. No clearing pass is needed after reset.
module contiguous_slot_allocator #(
  parameter int CHUNK_SLOTS = 64,
  parameter int MAX_CHUNKS  = 8,
  parameter int MAX_BLOCKS  = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire csa_pkg::csa_in_t   in_i,
  output logic                    res_valid_o,
  output csa_pkg::csa_out_t       res_o,
  input  wire logic               cfg_we_i,
  input  wire logic [3:0]         cfg_wdata_i
);
  import csa_pkg::*;

  localparam int CW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int OPW = $clog2(MAX_CHUNKS + 1);
  localparam int OW  = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int NW  = $clog2(CHUNK_SLOTS + 1);
  localparam int EW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int DW  = 32 + CW + OW + 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_RDCAP = 3'd3;
  localparam logic [2:0] S_WIN   = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [3:0]             chunk_limit_q;
  logic [OPW-1:0]         chunks_open_q, chunks_open_d;
  logic [31:0]            id_counter_q, id_counter_d;
  logic [1:0]             cmd_q, cmd_d;
  logic [6:0]             n_q, n_d;
  logic [31:0]            tid_q, tid_d;
  logic [31:0]            key_q, key_d;
  logic [EW:0]            scan_q, scan_d;
  logic                   pend_q, pend_d;
  logic [EW-1:0]          pidx_q, pidx_d;
  logic                   hit_q, hit_d;
  logic [EW-1:0]          hit_idx_q, hit_idx_d;
  logic                   free_q, free_d;
  logic [EW-1:0]          free_idx_q, free_idx_d;
  logic [EW-1:0]          ent_q, ent_d;
  logic [CW-1:0]          hit_chunk_q, hit_chunk_d;
  logic [OW-1:0]          hit_off_q, hit_off_d;
  logic [6:0]             hit_len_q, hit_len_d;
  logic [OPW-1:0]         chunk_q, chunk_d;
  logic [NW-1:0]          s_q, s_d;
  logic [CHUNK_SLOTS-1:0] row_q, row_d;
  logic                   res_valid_q, res_valid_d;
  csa_out_t               res_q, res_d;

  // Memory ports
  logic                   fm_re, fm_we;
  logic [CW-1:0]          fm_raddr, fm_waddr;
  logic [CHUNK_SLOTS-1:0] fm_rdata, fm_wdata;
  logic                   tbl_re, tbl_we, tbl_clr;
  logic [DW-1:0]          tbl_rdata, tbl_wdata;
  logic [MAX_BLOCKS-1:0]  tbl_valid;

  // Datapath helpers
  logic [NW-1:0]          len_sel;
  logic [CHUNK_SLOTS-1:0] run_mask;
  logic [NW-1:0]          s_last;
  logic                   win_ok;
  logic                   accept;
  logic                   commit;
  logic [CW-1:0]          com_chunk;
  logic [OW-1:0]          com_off;
  logic [31:0]            slot_abs;
  logic [31:0]            rd_id;
  logic [CW-1:0]          rd_chunk;
  logic [OW-1:0]          rd_off;
  logic [6:0]             rd_len;
  logic                   at_limit;

  csa_freemap #(.ROWS(MAX_CHUNKS), .WIDTH(CHUNK_SLOTS)) u_freemap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (fm_re),
    .raddr_i (fm_raddr),
    .rdata_o (fm_rdata),
    .we_i    (fm_we),
    .waddr_i (fm_waddr),
    .wdata_i (fm_wdata)
  );

  csa_table #(.DEPTH(MAX_BLOCKS), .DW(DW)) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (tbl_re),
    .raddr_i (scan_q[EW-1:0]),
    .rdata_o (tbl_rdata),
    .we_i    (tbl_we),
    .waddr_i (ent_q),
    .wdata_i (tbl_wdata),
    .clr_i   (tbl_clr),
    .caddr_i (hit_idx_q),
    .valid_o (tbl_valid)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign {rd_id, rd_chunk, rd_off, rd_len} = tbl_rdata;

  // Run mask of the current length, and the window test at start s
  assign len_sel  = (cmd_q == CMD_EVICT) ? NW'(hit_len_q) : NW'(n_q);
  assign run_mask = {CHUNK_SLOTS{1'b1}} >> (NW'(CHUNK_SLOTS) - len_sel);
  assign s_last   = NW'(CHUNK_SLOTS) - len_sel;
  assign win_ok   = (((row_q >> s_q) & run_mask) == run_mask);
  assign at_limit = (32'(chunks_open_q) >= 32'(chunk_limit_q)) ||
                    (32'(chunks_open_q) >= 32'(MAX_CHUNKS));

  assign slot_abs = (32'(commit ? com_chunk : hit_chunk_q) * 32'(CHUNK_SLOTS)) +
                    32'(commit ? com_off : hit_off_q);

  assign tbl_wdata = {key_q, com_chunk, com_off, n_q};

  // Command sequencer
  always_comb begin
    state_d       = state_q;
    chunks_open_d = chunks_open_q;
    id_counter_d  = id_counter_q;
    cmd_d         = cmd_q;
    n_d           = n_q;
    tid_d         = tid_q;
    key_d         = key_q;
    scan_d        = scan_q;
    pend_d        = 1'b0;
    pidx_d        = pidx_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    ent_d         = ent_q;
    hit_chunk_d   = hit_chunk_q;
    hit_off_d     = hit_off_q;
    hit_len_d     = hit_len_q;
    chunk_d       = chunk_q;
    s_d           = s_q;
    row_d         = row_q;
    res_valid_d   = 1'b0;
    res_d         = res_q;
    fm_re         = 1'b0;
    fm_raddr      = chunk_q[CW-1:0];
    fm_we         = 1'b0;
    fm_waddr      = chunk_q[CW-1:0];
    fm_wdata      = row_q;
    tbl_re        = 1'b0;
    tbl_we        = 1'b0;
    tbl_clr       = 1'b0;
    commit        = 1'b0;
    com_chunk     = chunk_q[CW-1:0];
    com_off       = s_q[OW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d  = in_i.command;
          n_d    = in_i.slots_wanted;
          tid_d  = in_i.target_id;
          key_d  = (in_i.command == CMD_CREATE) ? id_counter_q + 32'd1 : in_i.target_id;
          scan_d = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          if ((in_i.command == CMD_CREATE) &&
              ((in_i.slots_wanted == 7'd0) || (32'(in_i.slots_wanted) > 32'(CHUNK_SLOTS)))) begin
            res_valid_d = 1'b1;
            res_d       = '0;
            res_d.status   = STAT_BAD_SIZE;
            res_d.given_id = in_i.target_id;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next entry read, note the first empty entry
        if (!hit_q && (32'(scan_q) < 32'(MAX_BLOCKS))) begin
          tbl_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = scan_q[EW-1:0];
          scan_d = scan_q + 1'b1;
          if (!tbl_valid[scan_q[EW-1:0]] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = scan_q[EW-1:0];
          end
        end
        // Compare the entry read last cycle
        if (pend_q && !hit_q && tbl_valid[pidx_q] && (rd_id == key_q)) begin
          hit_d       = 1'b1;
          hit_idx_d   = pidx_q;
          hit_chunk_d = rd_chunk;
          hit_off_d   = rd_off;
          hit_len_d   = rd_len;
        end
        if (!pend_q && (hit_q || (32'(scan_q) >= 32'(MAX_BLOCKS)))) begin
          res_d          = '0;
          res_d.given_id = tid_q;
          if (cmd_q == CMD_CREATE) begin
            if (!hit_q && !free_q) begin
              res_valid_d  = 1'b1;
              res_d.status = STAT_TBL_FULL;
              state_d      = S_IDLE;
            end else begin
              ent_d   = hit_q ? hit_idx_q : free_idx_q;
              chunk_d = '0;
              state_d = S_CHK;
            end
          end else if (cmd_q == CMD_EVICT) begin
            if (!hit_q) begin
              res_valid_d  = 1'b1;
              res_d.status = STAT_NOT_FOUND;
              state_d      = S_IDLE;
            end else begin
              fm_re    = 1'b1;
              fm_raddr = hit_chunk_q;
              state_d  = S_RDCAP;
            end
          end else begin
            res_valid_d     = 1'b1;
            res_d.status    = STAT_OK;
            res_d.is_loaded = hit_q;
            state_d         = S_IDLE;
          end
        end
      end

      S_CHK: begin
        if (chunk_q < chunks_open_q) begin
          fm_re   = 1'b1;
          state_d = S_RDCAP;
        end else if (at_limit) begin
          res_valid_d    = 1'b1;
          res_d          = '0;
          res_d.status   = STAT_NO_SLOTS;
          res_d.given_id = tid_q;
          state_d        = S_IDLE;
        end else begin
          // Open a fresh chunk; the run starts at its first slot
          commit        = 1'b1;
          com_chunk     = chunks_open_q[CW-1:0];
          com_off       = '0;
          fm_waddr      = chunks_open_q[CW-1:0];
          fm_wdata      = ~run_mask;
          chunks_open_d = chunks_open_q + 1'b1;
        end
      end

      S_RDCAP: begin
        if (cmd_q == CMD_EVICT) begin
          // Return the block's slots and drop its entry
          fm_we       = 1'b1;
          fm_waddr    = hit_chunk_q;
          fm_wdata    = fm_rdata | (run_mask << hit_off_q);
          tbl_clr     = 1'b1;
          res_valid_d = 1'b1;
          res_d       = '0;
          res_d.status     = STAT_OK;
          res_d.given_id   = tid_q;
          res_d.first_slot = slot_abs[8:0];
          res_d.slot_count = hit_len_q;
          state_d     = S_IDLE;
        end else begin
          row_d   = fm_rdata;
          s_d     = '0;
          state_d = S_WIN;
        end
      end

      S_WIN: begin
        if (win_ok) begin
          commit   = 1'b1;
          fm_wdata = row_q & ~(run_mask << s_q);
        end else if (s_q == s_last) begin
          chunk_d = chunk_q + 1'b1;
          state_d = S_CHK;
        end else begin
          s_d = s_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Claim the run and the entry, advance the id
    if (commit) begin
      fm_we        = 1'b1;
      tbl_we       = 1'b1;
      id_counter_d = key_q;
      res_valid_d  = 1'b1;
      res_d        = '0;
      res_d.status     = STAT_OK;
      res_d.given_id   = key_q;
      res_d.first_slot = slot_abs[8:0];
      res_d.slot_count = n_q;
      state_d      = S_IDLE;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      chunk_limit_q <= CHUNK_LIMIT_RST;
      chunks_open_q <= '0;
      id_counter_q  <= '0;
      pend_q        <= 1'b0;
      hit_q         <= 1'b0;
      free_q        <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      chunks_open_q <= chunks_open_d;
      id_counter_q  <= id_counter_d;
      pend_q        <= pend_d;
      hit_q         <= hit_d;
      free_q        <= free_d;
      res_valid_q   <= res_valid_d;
      if (cfg_we_i) begin
        chunk_limit_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    n_q         <= n_d;
    tid_q       <= tid_d;
    key_q       <= key_d;
    scan_q      <= scan_d;
    pidx_q      <= pidx_d;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    ent_q       <= ent_d;
    hit_chunk_q <= hit_chunk_d;
    hit_off_q   <= hit_off_d;
    hit_len_q   <= hit_len_d;
    chunk_q     <= chunk_d;
    s_q         <= s_d;
    row_q       <= row_d;
    res_q       <= res_d;
  end

  // Open chunks never exceed the row count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(chunks_open_q) <= 32'(MAX_CHUNKS))
    else $error("chunk count overflow");

  // Table full is reported only with every entry live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == STAT_TBL_FULL)) |-> (&tbl_valid))
    else $error("table full with a free entry");

  // A row is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fm_re && fm_we))
    else $error("free map read/write overlap");

  // A successful create leaves its entry live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |=> tbl_valid[$past(ent_q)])
    else $error("created entry not live");

endmodule
`default_nettype wire

@@ tb/tb_contiguous_slot_allocator.sv @@
module tb_contiguous_slot_allocator;
  import csa_pkg::*;

  localparam int CHUNK_SLOTS = 64;
  localparam int MAX_CHUNKS  = 8;
  localparam int MAX_BLOCKS  = 64;
  localparam int TOTAL_SLOTS = CHUNK_SLOTS * MAX_CHUNKS;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  csa_in_t    in_i = '0;
  logic       res_valid_o;
  csa_out_t   res_o;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;

  contiguous_slot_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow allocator state
  bit          slot_free [TOTAL_SLOTS];
  int          open_chunks;
  logic [31:0] last_id;
  bit          ent_live [MAX_BLOCKS];
  logic [31:0] ent_id [MAX_BLOCKS];
  logic [8:0]  ent_low [MAX_BLOCKS];
  logic [6:0]  ent_len [MAX_BLOCKS];
  int          chunk_cap;

  csa_out_t pending_results[$];
  int       errors;
  int       burst_left;

  function automatic int find_live(logic [31:0] id);
    for (int e = 0; e < MAX_BLOCKS; e++) begin
      if (ent_live[e] && ent_id[e] == id) return e;
    end
    return -1;
  endfunction

  function automatic csa_out_t make_res(logic [2:0] st, logic [31:0] id, int first,
                                        int cnt, bit loaded);
    csa_out_t r;
    r.status     = st;
    r.given_id   = id;
    r.first_slot = first[8:0];
    r.slot_count = cnt[6:0];
    r.is_loaded  = loaded;
    return r;
  endfunction

  // Apply one command to the shadow state and return its result
  function automatic csa_out_t allocate_step(csa_in_t it);
    logic [31:0] new_id;
    int          n, e, lim, base, first;
    bit          found, ok;
    n = it.slots_wanted;
    if (it.command == CMD_CREATE) begin
      new_id = last_id + 32'd1;
      if (n == 0 || n > CHUNK_SLOTS) return make_res(STAT_BAD_SIZE, it.target_id, 0, 0, 0);
      e = find_live(new_id);
      if (e < 0) begin
        for (e = 0; e < MAX_BLOCKS; e++) if (!ent_live[e]) break;
        if (e >= MAX_BLOCKS) return make_res(STAT_TBL_FULL, it.target_id, 0, 0, 0);
      end
      found = 0;
      first = 0;
      // first fit, chunk by chunk, lowest start first
      for (int c = 0; c < open_chunks && !found; c++) begin
        base = c * CHUNK_SLOTS;
        for (int s = base; s <= base + CHUNK_SLOTS - n && !found; s++) begin
          ok = 1;
          for (int i = s; i < s + n; i++) if (!slot_free[i]) ok = 0;
          if (ok) begin
            found = 1;
            first = s;
          end
        end
      end
      if (!found) begin
        lim = chunk_cap < MAX_CHUNKS ? chunk_cap : MAX_CHUNKS;
        if (open_chunks >= lim) return make_res(STAT_NO_SLOTS, it.target_id, 0, 0, 0);
        first = open_chunks * CHUNK_SLOTS;
        open_chunks++;
      end
      for (int i = first; i < first + n; i++) slot_free[i] = 0;
      last_id     = new_id;
      ent_live[e] = 1;
      ent_id[e]   = new_id;
      ent_low[e]  = first[8:0];
      ent_len[e]  = n[6:0];
      return make_res(STAT_OK, new_id, first, n, 0);
    end
    e = find_live(it.target_id);
    if (it.command == CMD_EVICT) begin
      if (e < 0) return make_res(STAT_NOT_FOUND, it.target_id, 0, 0, 0);
      for (int i = ent_low[e]; i < ent_low[e] + ent_len[e]; i++) slot_free[i] = 1;
      ent_live[e] = 0;
      return make_res(STAT_OK, it.target_id, ent_low[e], ent_len[e], 0);
    end
    // query, and the unused code behaves the same
    return make_res(STAT_OK, it.target_id, 0, 0, e >= 0);
  endfunction

  // Present a command and hold it until the block takes the beat
  task automatic issue(csa_in_t it, bit known, csa_out_t typed);
    csa_out_t predicted;
    start_i <= 1'b1;
    in_i    <= it;
    do @(posedge clk_i); while (busy_o);
    predicted = allocate_step(it);
    pending_results = {pending_results, (known ? typed : predicted)};
  endtask

  task automatic write_chunk_limit(int v);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[3:0];
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    chunk_cap = v;
    @(posedge clk_i);
  endtask

  // Idle the sender between bursts, unless no_gaps is set
  task automatic pace(bit no_gaps);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if (!no_gaps) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [31:0] pick_id();
    int e0;
    e0 = $urandom_range(0, MAX_BLOCKS - 1);
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (ent_live[(e0 + k) % MAX_BLOCKS]) return ent_id[(e0 + k) % MAX_BLOCKS];
    end
    return $urandom();
  endfunction

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    csa_out_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, res_o.status); errors++;
        end
        if (res_o.given_id !== want.given_id) begin
          $error("given_id exp %0h got %0h", want.given_id, res_o.given_id); errors++;
        end
        if (res_o.first_slot !== want.first_slot) begin
          $error("first_slot exp %0d got %0d", want.first_slot, res_o.first_slot); errors++;
        end
        if (res_o.slot_count !== want.slot_count) begin
          $error("slot_count exp %0d got %0d", want.slot_count, res_o.slot_count); errors++;
        end
        if (res_o.is_loaded !== want.is_loaded) begin
          $error("is_loaded exp %0d got %0d", want.is_loaded, res_o.is_loaded); errors++;
        end
      end
    end
  end

  typedef struct {
    csa_in_t  it;
    bit       known;
    csa_out_t res;
  } stim_row_t;

  stim_row_t plan[$];

  // Append one stimulus row to the directed plan
  function automatic void queue_row(logic [1:0] cmd, int n, logic [31:0] tid, bit known,
                                    logic [2:0] st, logic [31:0] id, int first, int cnt,
                                    bit loaded);
    stim_row_t r;
    r.it.command      = cmd;
    r.it.slots_wanted = n[6:0];
    r.it.target_id    = tid;
    r.known           = known;
    r.res             = make_res(st, id, first, cnt, loaded);
    plan = {plan, r};
  endfunction

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    csa_in_t     it;
    csa_out_t    none;
    int          caps[12] = '{8, 2, 5, 1, 8, 3, 6, 4, 8, 7, 1, 8};
    int          style, pick;
    logic [1:0]  cmd;

    errors    = 0;
    burst_left = 0;
    none      = '0;
    foreach (slot_free[i]) slot_free[i] = 1;
    foreach (ent_live[i]) ent_live[i] = 0;
    open_chunks = 0;
    last_id     = '0;
    chunk_cap   = CHUNK_LIMIT_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: field extremes, every command, error codes
    queue_row(CMD_CREATE, 1, 32'h0, 1, STAT_OK, 32'd1, 0, 1, 0);
    queue_row(CMD_CREATE, 64, 32'hFFFF_FFFF, 1, STAT_OK, 32'd2, 64, 64, 0);
    queue_row(CMD_CREATE, 0, 32'hFFFF_FFFF, 1, STAT_BAD_SIZE, 32'hFFFF_FFFF, 0, 0, 0);
    queue_row(CMD_CREATE, 65, 32'h5A5A_5A5A, 1, STAT_BAD_SIZE, 32'h5A5A_5A5A, 0, 0, 0);
    queue_row(CMD_CREATE, 127, 32'h0, 1, STAT_BAD_SIZE, 32'h0, 0, 0, 0);
    queue_row(CMD_EVICT, 0, 32'd7, 1, STAT_NOT_FOUND, 32'd7, 0, 0, 0);
    queue_row(CMD_QUERY, 0, 32'd1, 1, STAT_OK, 32'd1, 0, 0, 1);
    queue_row(2'd3, 127, 32'd2, 1, STAT_OK, 32'd2, 0, 0, 1);
    queue_row(CMD_QUERY, 0, 32'hFFFF_FFFF, 1, STAT_OK, 32'hFFFF_FFFF, 0, 0, 0);
    queue_row(CMD_EVICT, 0, 32'd1, 1, STAT_OK, 32'd1, 0, 1, 0);
    queue_row(CMD_QUERY, 0, 32'd1, 1, STAT_OK, 32'd1, 0, 0, 0);
    queue_row(CMD_CREATE, 63, 32'h0, 1, STAT_OK, 32'd3, 0, 63, 0);
    queue_row(CMD_CREATE, 1, 32'h0, 1, STAT_OK, 32'd4, 63, 1, 0);
    queue_row(CMD_CREATE, 1, 32'h0, 1, STAT_OK, 32'd5, 128, 1, 0);
    queue_row(CMD_CREATE, 32, 32'hA5A5_A5A5, 0, STAT_OK, 0, 0, 0, 0);
    queue_row(CMD_EVICT, 0, 32'd3, 1, STAT_OK, 32'd3, 0, 63, 0);
    queue_row(CMD_CREATE, 10, 32'h0, 0, STAT_OK, 0, 0, 0, 0);
    queue_row(CMD_EVICT, 0, 32'd2, 1, STAT_OK, 32'd2, 64, 64, 0);
    queue_row(CMD_CREATE, 64, 32'h0, 0, STAT_OK, 0, 0, 0, 0);
    queue_row(CMD_EVICT, 0, 32'd4, 0, STAT_OK, 0, 0, 0, 0);
    foreach (plan[i]) issue(plan[i].it, plan[i].known, plan[i].res);

    // Random phases, each under its own chunk limit
    foreach (caps[p]) begin
      write_chunk_limit(caps[p]);
      style = p % 3;
      for (int k = 0; k < 125; k++) begin
        pace(p % 4 == 3);
        pick = $urandom_range(0, 99);
        if (style == 1) cmd = pick < 75 ? CMD_CREATE : (pick < 90 ? CMD_EVICT : CMD_QUERY);
        else if (style == 2) cmd = pick < 30 ? CMD_CREATE : (pick < 85 ? CMD_EVICT : CMD_QUERY);
        else cmd = pick < 45 ? CMD_CREATE : (pick < 80 ? CMD_EVICT : (pick < 97 ? CMD_QUERY : 2'd3));
        it.command = cmd;
        pick = $urandom_range(0, 99);
        if (pick < 5) it.slots_wanted = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
        else if (style == 1 || pick < 40) it.slots_wanted = 7'($urandom_range(1, 8));
        else it.slots_wanted = 7'($urandom_range(1, 64));
        it.target_id = (cmd != CMD_CREATE && $urandom_range(0, 9) < 8) ? pick_id() : $urandom();
        issue(it, 1'b0, none);
      end
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/csa_pkg.sv
hdl/csa_freemap.sv
hdl/csa_table.sv
hdl/contiguous_slot_allocator.sv
tb/tb_contiguous_slot_allocator.sv
